// File: sv/abr_pkg.sv
// Package: shared types and constants of the affine bilinear RGB resampler.
package abr_pkg;

   localparam int MaxSourceSide = 64;
   localparam int MaxTargetSide = 256;
   localparam int FractionBits  = 12;
   localparam int PosBits       = 24;
   localparam int StepBits      = 21;
   localparam int SideBits      = $clog2(MaxSourceSide);
   localparam int TSideBits     = $clog2(MaxTargetSide);
   localparam int StoreDepth    = MaxSourceSide * MaxSourceSide;
   localparam int AddrBits      = $clog2(StoreDepth);
   localparam int IntBits       = PosBits - FractionBits;
   localparam int CsrIdxBits    = 3;
   localparam int CsrDataBits   = 21;
   localparam int QueueDepth    = 2;

   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_BEGIN = 2'd1;
   localparam logic [1:0] CMD_EMIT  = 2'd2;
   localparam logic [1:0] CMD_NOP   = 2'd3;

   localparam logic [CsrIdxBits-1:0] REG_SRC_W = 3'd0;
   localparam logic [CsrIdxBits-1:0] REG_SRC_H = 3'd1;
   localparam logic [CsrIdxBits-1:0] REG_TGT_W = 3'd2;
   localparam logic [CsrIdxBits-1:0] REG_TGT_H = 3'd3;
   localparam logic [CsrIdxBits-1:0] REG_UX    = 3'd4;
   localparam logic [CsrIdxBits-1:0] REG_UY    = 3'd5;
   localparam logic [CsrIdxBits-1:0] REG_VX    = 3'd6;
   localparam logic [CsrIdxBits-1:0] REG_VY    = 3'd7;

   typedef struct packed {
      logic [1:0]         command;
      logic [11:0]        load_index;
      logic [7:0]         red_in;
      logic [7:0]         green_in;
      logic [7:0]         blue_in;
      logic signed [23:0] start_x;
      logic signed [23:0] start_y;
   } req_word_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic       row_end;
      logic       frame_end;
   } rsp_word_type;

   // classified work for the back end
   typedef struct packed {
      logic                    is_load;
      logic [AddrBits-1:0]     addr;
      logic [23:0]             pixel;
      logic                    in_bounds;
      logic [SideBits-1:0]     x;
      logic [SideBits-1:0]     y;
      logic [FractionBits-1:0] fx;
      logic [FractionBits-1:0] fy;
      logic                    row_end;
      logic                    frame_end;
   } job_type;

   typedef struct packed {
      logic [SideBits:0] src_w;
      logic [SideBits:0] src_h;
   } geom_type;

endpackage

// File: sv/abr_front.sv
// Front end: takes request words, walks the affine position, classifies jobs.
module abr_front
   import abr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CsrIdxBits-1:0]  csr_index,
   input  logic [CsrDataBits-1:0] csr_data,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_word_type           req_word,
   output logic                   job_valid,
   input  logic                   job_stall,
   output job_type                job,
   output geom_type               geom
);

   logic [6:0] src_w_ff, src_h_ff;
   logic [8:0] tgt_w_ff, tgt_h_ff;
   logic [StepBits-1:0] ux_ff, uy_ff, vx_ff, vy_ff;
   logic [PosBits-1:0] org_x_ff, org_y_ff, walk_x_ff, walk_y_ff;
   logic [PosBits-1:0] org_x_in, org_y_in, walk_x_in, walk_y_in;
   logic [TSideBits-1:0] col_ff, row_ff, col_in, row_in;
   logic [SideBits:0] sw, sh;
   logic [TSideBits:0] tw, th;
   logic [IntBits-1:0] ix, iy;
   logic accept, emit, row_last, frame_last, in_bounds;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= 7'd64;
         src_h_ff <= 7'd64;
         tgt_w_ff <= 9'd64;
         tgt_h_ff <= 9'd64;
         ux_ff    <= StepBits'(4096);
         uy_ff    <= '0;
         vx_ff    <= '0;
         vy_ff    <= StepBits'(4096);
      end else if (csr_write) begin
         unique case (csr_index)
            REG_SRC_W: src_w_ff <= csr_data[6:0];
            REG_SRC_H: src_h_ff <= csr_data[6:0];
            REG_TGT_W: tgt_w_ff <= csr_data[8:0];
            REG_TGT_H: tgt_h_ff <= csr_data[8:0];
            REG_UX:    ux_ff    <= csr_data;
            REG_UY:    uy_ff    <= csr_data;
            REG_VX:    vx_ff    <= csr_data;
            REG_VY:    vy_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      sw = (src_w_ff == '0) ? (SideBits+1)'(1) :
           (src_w_ff > 7'(MaxSourceSide)) ? (SideBits+1)'(MaxSourceSide) :
           (SideBits+1)'(src_w_ff);
      sh = (src_h_ff == '0) ? (SideBits+1)'(1) :
           (src_h_ff > 7'(MaxSourceSide)) ? (SideBits+1)'(MaxSourceSide) :
           (SideBits+1)'(src_h_ff);
      tw = (tgt_w_ff == '0) ? (TSideBits+1)'(1) :
           (tgt_w_ff > 9'(MaxTargetSide)) ? (TSideBits+1)'(MaxTargetSide) :
           (TSideBits+1)'(tgt_w_ff);
      th = (tgt_h_ff == '0) ? (TSideBits+1)'(1) :
           (tgt_h_ff > 9'(MaxTargetSide)) ? (TSideBits+1)'(MaxTargetSide) :
           (TSideBits+1)'(tgt_h_ff);
   end

   assign geom.src_w = sw;
   assign geom.src_h = sh;

   assign req_stall = job_stall;
   assign accept    = req_valid && !job_stall;
   assign emit      = accept && req_word.command == CMD_EMIT;

   assign ix = walk_x_ff[PosBits-1:FractionBits];
   assign iy = walk_y_ff[PosBits-1:FractionBits];
   assign in_bounds = !walk_x_ff[PosBits-1] && !walk_y_ff[PosBits-1]
                      && ix < IntBits'(sw) && iy < IntBits'(sh);
   assign row_last   = {1'b0, col_ff} >= tw - 1'b1;
   assign frame_last = row_last && {1'b0, row_ff} >= th - 1'b1;

   always_comb begin
      org_x_in  = org_x_ff;
      org_y_in  = org_y_ff;
      walk_x_in = walk_x_ff;
      walk_y_in = walk_y_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (accept && req_word.command == CMD_BEGIN) begin
         org_x_in  = req_word.start_x;
         org_y_in  = req_word.start_y;
         walk_x_in = req_word.start_x;
         walk_y_in = req_word.start_y;
         col_in    = '0;
         row_in    = '0;
      end else if (emit) begin
         if (row_last) begin
            org_x_in  = org_x_ff + PosBits'(signed'(vx_ff));
            org_y_in  = org_y_ff + PosBits'(signed'(vy_ff));
            walk_x_in = org_x_in;
            walk_y_in = org_y_in;
            col_in    = '0;
            row_in    = frame_last ? '0 : row_ff + 1'b1;
         end else begin
            walk_x_in = walk_x_ff + PosBits'(signed'(ux_ff));
            walk_y_in = walk_y_ff + PosBits'(signed'(uy_ff));
            col_in    = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         org_x_ff  <= '0;
         org_y_ff  <= '0;
         walk_x_ff <= '0;
         walk_y_ff <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         org_x_ff  <= org_x_in;
         org_y_ff  <= org_y_in;
         walk_x_ff <= walk_x_in;
         walk_y_ff <= walk_y_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   assign job_valid = req_valid && (req_word.command == CMD_EMIT ||
                      (req_word.command == CMD_LOAD &&
                       {1'b0, req_word.load_index} < 13'(StoreDepth)));
   always_comb begin
      job.is_load   = req_word.command == CMD_LOAD;
      job.addr      = AddrBits'(req_word.load_index);
      job.pixel     = {req_word.red_in, req_word.green_in, req_word.blue_in};
      job.in_bounds = in_bounds;
      job.x         = SideBits'(ix);
      job.y         = SideBits'(iy);
      job.fx        = walk_x_ff[FractionBits-1:0];
      job.fy        = walk_y_ff[FractionBits-1:0];
      job.row_end   = row_last;
      job.frame_end = frame_last;
   end

endmodule

// File: sv/abr_queue.sv
// Short job queue between front and back ends.
module abr_queue
   import abr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_stall,
   input  job_type in_job,
   output logic    out_valid,
   input  logic    out_stall,
   output job_type out_job
);

   localparam int PtrBits = $clog2(QueueDepth);

   job_type slot_ff [QueueDepth];
   logic [PtrBits-1:0] wr_ff, rd_ff;
   logic [PtrBits:0] cnt_ff;
   logic push, pop;

   assign in_stall  = cnt_ff == (PtrBits+1)'(QueueDepth);
   assign out_valid = cnt_ff != '0;
   assign out_job   = slot_ff[rd_ff];
   assign push = in_valid && !in_stall;
   assign pop  = out_valid && !out_stall;

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= in_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (PtrBits+1)'(push) - (PtrBits+1)'(pop);
      end
   end

endmodule

// File: sv/abr_back.sv
// Back end: pixel store, four-tap fetch, bilinear blend and result register.
module abr_back
   import abr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  geom_type     geom,
   input  logic         job_valid,
   output logic         job_stall,
   input  job_type      job,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FETCH = 2'd1;
   localparam logic [1:0] ST_MIX   = 2'd2;
   localparam logic [1:0] ST_OUT   = 2'd3;
   localparam int One = 1 << FractionBits;

   logic [23:0] store [StoreDepth];
   logic [1:0] state_ff, state_in;
   logic [1:0] tap_ff;
   job_type job_ff;
   logic [23:0] rd_ff;
   logic [23:0] p_ff [4];
   logic [AddrBits-1:0] addr;
   logic [SideBits-1:0] nx, ny, tx, ty;
   logic [FractionBits:0] ox, oy;
   logic [8+FractionBits:0] h0_ff [3], h1_ff [3], h0, h1;
   logic [8+2*FractionBits+1:0] sum;
   logic [7:0] chan [3];
   rsp_word_type out_ff;
   logic rsp_valid_ff;

   assign job_stall = state_ff != ST_IDLE;
   assign nx = ({1'b0, job_ff.x} == geom.src_w - 1'b1) ? job_ff.x : job_ff.x + 1'b1;
   assign ny = ({1'b0, job_ff.y} == geom.src_h - 1'b1) ? job_ff.y : job_ff.y + 1'b1;
   assign tx = tap_ff[0] ? nx : job_ff.x;
   assign ty = tap_ff[1] ? ny : job_ff.y;
   assign addr = AddrBits'(ty * geom.src_w + (SideBits+1)'(tx));
   assign ox = (FractionBits+1)'(One) - job_ff.fx;
   assign oy = (FractionBits+1)'(One) - job_ff.fy;

   always_ff @(posedge clock) begin
      if (job_valid && !job_stall && job.is_load) store[job.addr] <= job.pixel;
      rd_ff <= store[addr];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (job_valid && !job.is_load)
                      state_in = job.in_bounds ? ST_FETCH : ST_OUT;
         ST_FETCH: if (tap_ff == 2'd3) state_in = ST_MIX;
         ST_MIX:   state_in = ST_OUT;
         ST_OUT:   if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // taps: rd_ff holds tap k in the cycle after it is addressed
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_FETCH) tap_ff <= tap_ff + 1'b1;
         else tap_ff <= '0;
         if (state_ff == ST_OUT && state_in == ST_IDLE) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE) job_ff <= job;
      if (state_ff == ST_FETCH && tap_ff != 2'd0) p_ff[tap_ff - 1'b1] <= rd_ff;
      if (state_ff == ST_MIX) p_ff[3] <= rd_ff;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_MIX) begin
         for (int c = 0; c < 3; c++) begin
            h0_ff[c] <= (9+FractionBits)'(p_ff[0][8*c +: 8] * ox
                        + p_ff[1][8*c +: 8] * job_ff.fx);
            h1_ff[c] <= (9+FractionBits)'(p_ff[2][8*c +: 8] * ox
                        + rd_ff[8*c +: 8] * job_ff.fx);
         end
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         h0 = h0_ff[c];
         h1 = h1_ff[c];
         sum = (10+2*FractionBits)'(h0 * oy + h1 * job_ff.fy);
         chan[c] = job_ff.in_bounds ? sum[2*FractionBits +: 8] : 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && state_in == ST_IDLE) begin
         out_ff.blue_out  <= chan[0];
         out_ff.green_out <= chan[1];
         out_ff.red_out   <= chan[2];
         out_ff.row_end   <= job_ff.row_end;
         out_ff.frame_end <= job_ff.frame_end;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = out_ff;

endmodule

// File: sv/affine_bilinear_rgb_resampler_unit.sv
// Top level of the affine bilinear RGB resampler.
// Request channel (req_valid/req_stall/req_word) takes commands: load writes
// one RGB pixel into the 4096-entry store, begin sets the start position,
// emit yields one destination pixel on the response channel
// (rsp_valid/rsp_stall/rsp_word) with row and frame end marks.
// The front end walks the affine position and classifies each word in the
// cycle it is accepted; a two-entry queue feeds the back end.
// An inside pixel passes these back-end steps: the cycle that takes the
// job, four serial reads of the store's single read port, a horizontal
// blend cycle and a vertical blend cycle that loads the result register.
// A black pixel goes from the taking cycle to the result register; a load
// is written into the store in the cycle the back end takes it.
// A stalled result holds in the output register; the back end waits and the
// queue fills, then req_stall rises. Reset clears position, counters and
// handshake state and sets the CSRs to their defaults; the pixel store and
// the data registers are not cleared.
module affine_bilinear_rgb_resampler_unit
   import abr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CsrIdxBits-1:0]  csr_index,
   input  logic [CsrDataBits-1:0] csr_data,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_word_type           req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_word_type           rsp_word
);

   logic f_valid, f_stall, b_valid, b_stall;
   job_type f_job, b_job;
   geom_type geom;

   abr_front u_front (
      .clock, .reset, .csr_write, .csr_index, .csr_data,
      .req_valid, .req_stall, .req_word,
      .job_valid(f_valid), .job_stall(f_stall), .job(f_job), .geom
   );

   abr_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_stall(f_stall), .in_job(f_job),
      .out_valid(b_valid), .out_stall(b_stall), .out_job(b_job)
   );

   abr_back u_back (
      .clock, .reset, .geom,
      .job_valid(b_valid), .job_stall(b_stall), .job(b_job),
      .rsp_valid, .rsp_stall, .rsp_word
   );

endmodule

// File: sv/abr_checker.sv
// Port-level checker for the resampler, bound to the top level.
module abr_checker
   import abr_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_word
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("response changed while stalled");

   a_frame_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.frame_end |-> rsp_word.row_end)
      else $error("frame end without row end");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_no_early: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("response or stall right after reset");

endmodule

bind affine_bilinear_rgb_resampler_unit abr_checker u_abr_checker (
   .clock, .reset, .req_stall,
   .rsp_valid, .rsp_stall, .rsp_word
);
